/* rtl/pidl_pkg.sv */
// ----------------------------------------------------------------------------
// pidl_pkg: shared types for the positional insert/delete list
// Opcodes, status codes, request/result structs and cell controls.
// ----------------------------------------------------------------------------
`default_nettype none

package pidl_pkg;

  localparam int DEPTH = 32;
  localparam int CW    = $clog2(DEPTH + 1);     // count width
  localparam int IW    = $clog2(DEPTH);         // cell index width
  localparam int PW    = 6;                     // position field width
  localparam int CMPW  = (CW > PW) ? CW : PW;   // common compare width

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    OP_APPEND    = 3'd0,
    OP_PUSH      = 3'd1,
    OP_INSERT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP_FWD  = 3'd6,
    OP_DUMP_REV  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } st_t;

  typedef struct packed {
    op_t             opcode;
    word_t           value;
    logic [PW-1:0]   position;
  } in_req_t;

  typedef struct packed {
    word_t           read_value;
    logic [5:0]      element_count;
    st_t             status;
    logic            last;
  } out_res_t;

  // What one cell loads at the next edge
  typedef enum logic [2:0] {
    C_HOLD,
    C_LOAD,   // new word from the request
    C_SHL,    // take right neighbor (close a gap / rotate toward front)
    C_SHR,    // take left neighbor (open a gap / rotate toward back)
    C_WRAP    // take the wrap-around word during a dump rotation
  } cell_op_t;

endpackage

`default_nettype wire

/* rtl/pidl_cell.sv */
// ----------------------------------------------------------------------------
// pidl_cell: one storage cell of the list chain
// Holds one word and loads from the request, a neighbor or the wrap bus.
// ----------------------------------------------------------------------------
`default_nettype none

module pidl_cell
  import pidl_pkg::*;
(
  input  wire logic     clk,
  input  wire cell_op_t ctl,
  input  wire word_t    left_q,
  input  wire word_t    right_q,
  input  wire word_t    ins_val,
  input  wire word_t    wrap_val,
  output word_t         q
);

  word_t data_r;
  word_t data_nxt;

  always_comb begin
    case (ctl)
      C_HOLD:  data_nxt = data_r;
      C_LOAD:  data_nxt = ins_val;
      C_SHL:   data_nxt = right_q;
      C_SHR:   data_nxt = left_q;
      C_WRAP:  data_nxt = wrap_val;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

/* rtl/positional_insert_delete_list_unit.sv */
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit: ordered list with positional edits
// Top level: request decode, cell chain control, dump sequencer, result reg.
// ----------------------------------------------------------------------------
// The list lives in a chain of DEPTH cells, element k in cell k. Append,
// push, insert and the three deletes are done when the request is taken:
// the cells at and beyond the position move to a neighbor or load the new
// word at the same edge, and one result with status and new count follows.
// A dump of a non-empty list holds off the input from the request until
// its last element is emitted, one element per free output slot. An empty
// dump returns one result. During a dump the occupied part of the chain
// rotates one step per emitted element and is back in place after the last
// one. No new request is taken while a dump runs. A result waits in a single
// output register; a request is taken whenever that register is free or being emptied in the same cycle.
`default_nettype none

module positional_insert_delete_list_unit
  import pidl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_res_t      out_data
);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [CW-1:0]   rem_r;
  logic            rev_r;
  logic            out_valid_r;
  out_res_t        out_data_r;

  logic            slot_free;
  logic            acc;
  logic            dump_step;

  // decode
  logic            is_dump;
  logic            do_ins;
  logic            do_del;
  logic [CMPW-1:0] ins_pos;
  logic [CMPW-1:0] del_pos;
  st_t             st;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] last_x;
  logic [CW-1:0]   last_idx;
  logic            full;
  logic            empty;

  word_t           cell_q [DEPTH];
  cell_op_t        cell_ctl [DEPTH];
  word_t           head_w;
  word_t           tail_w;
  word_t           wrap_w;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign acc       = in_valid && in_ready;
  assign dump_step = (state_r == S_DUMP) && slot_free;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign last_idx = count_r - CW'(1);
  assign pos_x    = CMPW'(in_data.position);
  assign cnt_x    = CMPW'(count_r);
  assign last_x   = CMPW'(last_idx);
  assign is_dump  = (in_data.opcode == OP_DUMP_FWD) || (in_data.opcode == OP_DUMP_REV);

  always_comb begin
    st      = ST_DONE;
    do_ins  = 1'b0;
    do_del  = 1'b0;
    ins_pos = cnt_x;
    del_pos = '0;
    case (in_data.opcode)
      OP_APPEND: begin
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_PUSH: begin
        ins_pos = '0;
        if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_INSERT: begin
        ins_pos = pos_x;
        if (pos_x > cnt_x) st = ST_RANGE;
        else if (full) st = ST_FULL;
        else do_ins = 1'b1;
      end
      OP_DEL_FRONT: begin
        if (empty) st = ST_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_BACK: begin
        del_pos = last_x;
        if (empty) st = ST_EMPTY;
        else do_del = 1'b1;
      end
      OP_DEL_AT: begin
        del_pos = pos_x;
        if (empty) st = ST_EMPTY;
        else if (pos_x >= cnt_x) st = ST_RANGE;
        else do_del = 1'b1;
      end
      default: begin
        st = ST_DONE;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (acc && do_ins) count_nxt = count_r + CW'(1);
    else if (acc && do_del) count_nxt = count_r - CW'(1);
  end

  // head and tail of the occupied region; tail is valid whenever count > 0
  assign head_w = cell_q[0];
  assign tail_w = cell_q[last_idx[IW-1:0]];
  assign wrap_w = rev_r ? tail_w : head_w;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      cell_ctl[i] = C_HOLD;
      if (acc && do_ins) begin
        if (CMPW'(i) > ins_pos) cell_ctl[i] = C_SHR;
        else if (CMPW'(i) == ins_pos) cell_ctl[i] = C_LOAD;
      end else if (acc && do_del) begin
        if (CMPW'(i) >= del_pos) cell_ctl[i] = C_SHL;
      end else if (dump_step) begin
        if (!rev_r) begin
          if (CMPW'(i) < last_x) cell_ctl[i] = C_SHL;
          else if (CMPW'(i) == last_x) cell_ctl[i] = C_WRAP;
        end else begin
          if (i == 0) cell_ctl[i] = C_WRAP;
          else if (CMPW'(i) <= last_x) cell_ctl[i] = C_SHR;
        end
      end
    end

    pidl_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .left_q   (cell_q[(i == 0) ? i : i - 1]),
      .right_q  (cell_q[(i == DEPTH - 1) ? i : i + 1]),
      .ins_val  (in_data.value),
      .wrap_val (wrap_w),
      .q        (cell_q[i])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (is_dump && !empty) begin
              state_r <= S_DUMP;
              rem_r   <= count_r;
              rev_r   <= (in_data.opcode == OP_DUMP_REV);
            end else begin
              out_valid_r              <= 1'b1;
              out_data_r.read_value    <= '0;
              out_data_r.element_count <= 6'(count_nxt);
              out_data_r.status        <= is_dump ? ST_EMPTY : st;
              out_data_r.last          <= 1'b1;
            end
          end
        end
        S_DUMP: begin
          if (dump_step) begin
            out_valid_r              <= 1'b1;
            out_data_r.read_value    <= rev_r ? tail_w : head_w;
            out_data_r.element_count <= 6'(count_r);
            out_data_r.status        <= ST_DONE;
            out_data_r.last          <= (rem_r == CW'(1));
            rem_r                    <= rem_r - CW'(1);
            if (rem_r == CW'(1)) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_count_hold_dump: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |=> $stable(count_r))
    else $error("count changed during a dump");

  a_non_last_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last) |-> (state_r == S_DUMP))
    else $error("non-final result outside a dump");

  a_dump_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |-> (rem_r != '0) && (rem_r <= count_r))
    else $error("dump counter out of range");

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for positional_insert_delete_list_unit
// Drives append/push/insert/delete/dump requests over valid/ready, predicts
// every result from a shadow list and checks each field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pidl_pkg::*;

  typedef struct packed {
    logic    drain;    // hold this request until every result is back
    in_req_t req;
  } pending_req_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_data;

  pending_req_t pending_reqs[$];
  out_res_t     expected_results[$];

  // shadow list
  word_t       list_words [DEPTH];
  int unsigned list_len = 0;
  int unsigned gen_len = 0;

  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_results = 0;
  int unsigned n_dumps = 0;
  int unsigned status_seen [4];
  int unsigned send_gap = 0;
  int unsigned ready_hold = 0;
  bit          long_hold_done = 1'b0;

  positional_insert_delete_list_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void expect_result(word_t v, st_t st, logic lst);
    out_res_t res;
    res.read_value    = v;
    res.element_count = list_len[5:0];
    res.status        = st;
    res.last          = lst;
    expected_results.push_back(res);
  endfunction

  function automatic void open_slot(int unsigned p, word_t v);
    for (int unsigned i = list_len; i > p; i--) list_words[i] = list_words[i-1];
    list_words[p] = v;
    list_len++;
  endfunction

  function automatic void close_slot(int unsigned p);
    for (int unsigned i = p; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
  endfunction

  function automatic void apply_request(in_req_t r);
    st_t         st;
    int unsigned p;
    st = ST_DONE;
    p  = r.position;
    if (r.opcode == OP_DUMP_FWD || r.opcode == OP_DUMP_REV) begin
      n_dumps++;
      if (list_len == 0) begin
        expect_result('0, ST_EMPTY, 1'b1);
      end else begin
        for (int unsigned i = 0; i < list_len; i++) begin
          expect_result(list_words[(r.opcode == OP_DUMP_FWD) ? i : list_len - 1 - i],
                        ST_DONE, i + 1 == list_len);
        end
      end
      return;
    end
    case (r.opcode)
      OP_APPEND: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else open_slot(list_len, r.value);
      end
      OP_PUSH: begin
        if (list_len >= DEPTH) st = ST_FULL;
        else open_slot(0, r.value);
      end
      OP_INSERT: begin
        // range test wins over the full test
        if (p > list_len) st = ST_RANGE;
        else if (list_len >= DEPTH) st = ST_FULL;
        else open_slot(p, r.value);
      end
      OP_DEL_FRONT: begin
        if (list_len == 0) st = ST_EMPTY;
        else close_slot(0);
      end
      OP_DEL_BACK: begin
        if (list_len == 0) st = ST_EMPTY;
        else list_len--;
      end
      default: begin
        if (list_len == 0) st = ST_EMPTY;
        else if (p >= list_len) st = ST_RANGE;
        else close_slot(p);
      end
    endcase
    expect_result('0, st, 1'b1);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_result(out_res_t got);
    out_res_t want;
    n_results++;
    status_seen[got.status]++;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual value %h count %0d status %0d last %b",
               $time, got.read_value, got.element_count, got.status, got.last);
      errors++;
      return;
    end
    want = expected_results.pop_front();
    field_check("read_value", want.read_value, got.read_value);
    field_check("element_count", 32'(want.element_count), 32'(got.element_count));
    field_check("status", 32'(want.status), 32'(got.status));
    field_check("last", 32'(want.last), 32'(got.last));
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void queue_op(op_t op, word_t v = '0, int unsigned p = 0);
    pending_req_t item;
    item.drain        = 1'b0;
    item.req.opcode   = op;
    item.req.value    = v;
    item.req.position = p[PW-1:0];
    pending_reqs.push_back(item);
    // track the length only, to aim positions at the live range
    case (op)
      OP_APPEND, OP_PUSH: if (gen_len < DEPTH) gen_len++;
      OP_INSERT:          if (p <= gen_len && gen_len < DEPTH) gen_len++;
      OP_DEL_FRONT, OP_DEL_BACK: if (gen_len > 0) gen_len--;
      OP_DEL_AT:          if (p < gen_len) gen_len--;
      default: ;
    endcase
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // mostly inside 0..span, now and then anywhere the field allows
  function automatic int unsigned pick_pos(int unsigned span);
    if ($urandom_range(0, 5) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, span);
  endfunction

  function automatic op_t pick_dump();
    return $urandom_range(0, 1) ? OP_DUMP_FWD : OP_DUMP_REV;
  endfunction

  function automatic void queue_fill();
    while (gen_len < DEPTH) begin
      case ($urandom_range(0, 2))
        0:       queue_op(OP_APPEND, rand_word());
        1:       queue_op(OP_PUSH, rand_word());
        default: queue_op(OP_INSERT, rand_word(), pick_pos(gen_len));
      endcase
    end
    queue_op(OP_APPEND, rand_word());
    queue_op(OP_PUSH, rand_word());
    queue_op(OP_INSERT, rand_word(), DEPTH);
    queue_op(OP_INSERT, rand_word(), DEPTH + 1);
    queue_op(OP_DEL_AT, '0, DEPTH);
    queue_op(pick_dump());
  endfunction

  function automatic void queue_drain();
    while (gen_len > 0) begin
      case ($urandom_range(0, 2))
        0:       queue_op(OP_DEL_FRONT);
        1:       queue_op(OP_DEL_BACK);
        default: queue_op(OP_DEL_AT, '0, pick_pos(gen_len - 1));
      endcase
    end
    queue_op(op_t'($urandom_range(3, 5)), '0, $urandom_range(0, 63));
    queue_op(pick_dump());
  endfunction

  function automatic void queue_mixed(int unsigned n);
    int unsigned sel;
    repeat (n) begin
      sel = $urandom_range(0, 9);
      if (sel > 7) queue_op(OP_APPEND, rand_word());
      else if (op_t'(sel) == OP_INSERT) queue_op(OP_INSERT, rand_word(), pick_pos(gen_len));
      else if (op_t'(sel) == OP_DEL_AT)
        queue_op(OP_DEL_AT, '0, pick_pos(gen_len == 0 ? 0 : gen_len - 1));
      else queue_op(op_t'(sel), rand_word(), $urandom_range(0, 63));
    end
  endfunction

  function automatic bit in_last_part();
    return pending_reqs.size() < 40;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_request(in_data);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_reqs[0].drain && expected_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!in_last_part() && !n_sent[5] && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          in_data  <= pending_reqs[0].req;
          in_valid <= 1'b1;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) check_result(out_data);
      if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && n_results >= 80) begin
        // back up the result path while the sender keeps offering requests
        long_hold_done = 1'b1;
        ready_hold     = 249;
        out_ready <= 1'b0;
      end else if (!in_last_part() && !n_results[4] && $urandom_range(0, 5) == 0) begin
        ready_hold = $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    pending_req_t tmp;

    // empty list: dumps and deletes flag empty, empty wins over range
    queue_op(OP_DUMP_FWD);
    queue_op(OP_DUMP_REV);
    queue_op(OP_DEL_FRONT);
    queue_op(OP_DEL_BACK);
    queue_op(OP_DEL_AT, '0, 40);
    queue_op(OP_APPEND, 32'h7fff_ffff);
    queue_op(OP_PUSH, 32'h8000_0000);
    queue_op(OP_INSERT, '0, 1);
    queue_op(OP_INSERT, '1, 3);           // position equal to count acts as append
    queue_op(OP_INSERT, 32'h5a5a_a5a5, 5);
    queue_op(OP_INSERT, 32'h1234_5678, 63);
    queue_op(OP_DUMP_FWD);
    queue_op(OP_DUMP_REV);
    queue_op(OP_DEL_AT, '0, 4);           // at count: out of range
    queue_op(OP_DEL_AT, '0, 63);
    queue_op(OP_DEL_AT, '0, 1);
    queue_op(OP_DEL_FRONT);
    queue_op(OP_DEL_BACK);
    queue_op(OP_DUMP_FWD);
    queue_op(OP_DEL_BACK);
    queue_op(OP_DUMP_REV);

    queue_fill();
    while (pending_reqs.size() < 220) begin
      case ($urandom_range(0, 5))
        0:       queue_fill();
        1:       queue_drain();
        default: queue_mixed($urandom_range(4, 12));
      endcase
    end
    tmp       = pending_reqs[110];
    tmp.drain = 1'b1;
    pending_reqs[110] = tmp;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d requests (%0d dumps) and %0d results", n_sent, n_dumps, n_results);
    $display("Status mix done/range/empty/full: %0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
